/* rtl/core/tlrd_pkg.sv */
// Package for the tile run-length decoder: widths, defaults, the front-end phase
// type and the run record passed from the front end to the back end.
// No dependencies.
package tlrd_pkg;

  localparam int GRID_WIDTH_DEF  = 60;
  localparam int GRID_HEIGHT_DEF = 25;

  localparam int BYTE_W  = 8;
  localparam int ELEM_W  = 7;
  localparam int COLOR_W = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 6;
  localparam int LEN_W   = 9;   // run length 1 to 256
  localparam int SEGC_W  = 3;   // counts emitted segments up to the limit

  localparam int MAX_SEGS    = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] SINGLE_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] ELEM_MASK   = 8'h7F;

  typedef enum logic [1:0] {
    PH_ELEMENT = 2'd0,
    PH_COLOR   = 2'd1,
    PH_COUNT   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  element;
    logic [COLOR_W-1:0] color;
    logic [LEN_W-1:0]   len;
  } run_t;

endpackage

/* rtl/core/tlrd_front.sv */
// Front end of the tile run-length decoder: takes stream words, tracks the
// element/colour/count phase and issues one complete run record. Uses tlrd_pkg.
module tlrd_front
  import tlrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              run_push,
  output run_t              run_word
);

  phase_t             phase;
  phase_t             phase_next;
  logic [ELEM_W-1:0]  held_element;
  logic               held_single;
  logic [COLOR_W-1:0] held_color;

  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (phase)
        PH_COLOR: phase_next = held_single ? PH_ELEMENT : PH_COUNT;
        PH_COUNT: phase_next = PH_ELEMENT;
        default:  phase_next = PH_COLOR;
      endcase
    end
  end

  always_comb begin
    run_push         = 1'b0;
    run_word.element = held_element;
    run_word.color   = held_color;
    run_word.len     = LEN_W'(1);
    unique case (phase)
      PH_COLOR: begin
        run_word.color = data_byte;
        run_push       = take && held_single;
      end
      PH_COUNT: begin
        run_word.len = (data_byte == '0) ? LEN_W'(256) : {1'b0, data_byte};
        run_push     = take;
      end
      default: run_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ELEMENT;
      held_element <= '0;
      held_single  <= 1'b0;
      held_color   <= '0;
    end else begin
      phase <= phase_next;
      if (take && phase == PH_COLOR) begin
        held_color <= data_byte;
      end
      if (take && phase != PH_COLOR && phase != PH_COUNT) begin
        held_element <= ELEM_W'(data_byte & ELEM_MASK);
        held_single  <= |(data_byte & SINGLE_MASK);
      end
    end
  end

endmodule

/* rtl/core/tlrd_queue.sv */
// Short queue of run records between the front end and the back end.
// Uses tlrd_pkg.
module tlrd_queue
  import tlrd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  run_t wr_word,
  input  logic rd_en,
  output run_t rd_word,
  output logic q_full,
  output logic q_empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  run_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign rd_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/tlrd_back.sv */
// Back end of the tile run-length decoder: walks a run over the grid one row
// segment per cycle unless an unpopped result stalls it, and registers the result word. Uses tlrd_pkg.
module tlrd_back
  import tlrd_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  run_t               q_word,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [ELEM_W-1:0]  tile_element,
  output logic [COLOR_W-1:0] tile_color,
  output logic [ROW_W-1:0]   row,
  output logic [COL_W-1:0]   col_start,
  output logic [COL_W-1:0]   seg_len,
  output logic               run_last,
  output logic               board_done
);

  localparam logic [COL_W:0]  COL_END = (COL_W + 1)'(GRID_WIDTH);
  localparam logic [ROW_W:0]  ROW_END = (ROW_W + 1)'(GRID_HEIGHT);

  logic               busy;
  logic [ELEM_W-1:0]  run_elem;
  logic [COLOR_W-1:0] run_color;
  logic [LEN_W-1:0]   left;
  logic [SEGC_W-1:0]  seg_cnt;
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic               out_valid;

  logic [COL_W:0]     room;
  logic [COL_W-1:0]   seg;
  logic [COL_W:0]     col_sum;
  logic [ROW_W:0]     row_inc;
  logic               wrap;
  logic               done;
  logic [LEN_W-1:0]   left_next;
  logic               skip;
  logic               step;
  logic               emit;

  always_comb begin
    room      = COL_END + (COL_W + 1)'(1) - {1'b0, cur_col};
    seg       = (left < {{(LEN_W - COL_W - 1){1'b0}}, room}) ? left[COL_W-1:0]
                                                             : room[COL_W-1:0];
    col_sum   = {1'b0, cur_col} + {1'b0, seg};
    wrap      = col_sum > COL_END;
    row_inc   = {1'b0, cur_row} + (ROW_W + 1)'(1);
    done      = wrap && (row_inc > ROW_END);
    left_next = done ? '0 : left - {{(LEN_W - COL_W){1'b0}}, seg};
    // Segments beyond the limit still move the position but are not emitted.
    skip      = (seg_cnt >= SEGC_W'(MAX_SEGS));
    step      = busy && (skip || !out_valid || pop);
    emit      = step && !skip;
    q_pop     = !busy && !q_empty;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (emit) begin
      tile_element <= run_elem;
      tile_color   <= run_color;
      row          <= cur_row;
      col_start    <= cur_col;
      seg_len      <= seg;
      run_last     <= (left_next == '0);
      board_done   <= done;
    end
    if (q_pop) begin
      run_elem  <= q_word.element;
      run_color <= q_word.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      left      <= '0;
      seg_cnt   <= '0;
      cur_col   <= COL_W'(1);
      cur_row   <= ROW_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy    <= 1'b1;
        left    <= q_word.len;
        seg_cnt <= '0;
      end else if (step) begin
        left <= left_next;
        busy <= (left_next != '0);
        if (!skip) begin
          seg_cnt <= seg_cnt + SEGC_W'(1);
        end
        if (wrap) begin
          cur_col <= COL_W'(1);
          cur_row <= done ? ROW_W'(1) : row_inc[ROW_W-1:0];
        end else begin
          cur_col <= col_sum[COL_W-1:0];
        end
      end
    end
  end

endmodule

/* rtl/core/tile_run_length_decoder_top.sv */
// Top level of the tile run-length decoder: front end, run queue and back end.
// Depends on tlrd_pkg, tlrd_front, tlrd_queue and tlrd_back.
//
//   Channel  | Direction | Handshake   | Word
//   ---------+-----------+-------------+--------------------------------------------
//   stream   | in        | push / full | data_byte
//   segments | out       | pop / empty | tile_element, tile_color, row, col_start,
//            |           |             | seg_len, run_last, board_done
//
// A stream word is taken when push is high and full is low; element words only
// set the held element. A completed run enters a two-deep run queue, and the back
// end walks it over the grid, emitting one row segment per cycle while the result
// register is free or being popped. The back end takes a run from the queue only
// when idle, so the next run waits until the current one is finished.
// Reset is synchronous and active high; it clears the phase, the queue, the
// position (column 1, row 1) and the valid flag of the result register.
// full rises only when the run queue holds two runs; a stalled result holds the
// back end, while the front end keeps taking words until the queue fills.
module tile_run_length_decoder_top
  import tlrd_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               pop,
  output logic               empty,
  output logic [ELEM_W-1:0]  tile_element,
  output logic [COLOR_W-1:0] tile_color,
  output logic [ROW_W-1:0]   row,
  output logic [COL_W-1:0]   col_start,
  output logic [COL_W-1:0]   seg_len,
  output logic               run_last,
  output logic               board_done
);

  // A pushed word is taken whenever the run queue has room.
  logic take;
  logic run_push;
  run_t run_word;
  logic q_full;
  logic q_empty;
  logic q_pop;
  run_t q_word;

  assign full = q_full;
  assign take = push && !q_full;

  tlrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .run_push  (run_push),
    .run_word  (run_word)
  );

  tlrd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (run_push),
    .wr_word (run_word),
    .rd_en   (q_pop),
    .rd_word (q_word),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // The back end owns the grid position, so board wrap-around lives there.
  tlrd_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .tile_element (tile_element),
    .tile_color   (tile_color),
    .row          (row),
    .col_start    (col_start),
    .seg_len      (seg_len),
    .run_last     (run_last),
    .board_done   (board_done)
  );

endmodule
